### sv/adam_pkg.sv
`default_nettype none
package adam_pkg;

    localparam int NUM_PARAMS = 4096;
    localparam int MEM_AW     = $clog2(NUM_PARAMS);
    localparam int IDX_W      = 12;
    localparam int VAL_W      = 32;
    localparam int RATE_W     = 24;
    localparam int CFG_IDX_W  = 8;
    localparam int POW_W      = 25;

    localparam logic [POW_W-1:0] ONE_Q24 = POW_W'(1) << 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BETA_ONE     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_BETA_TWO     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON_TERM = CFG_IDX_W'(3);

    localparam logic [RATE_W-1:0] LEARN_RATE_RST   = RATE_W'(16777);
    localparam logic [RATE_W-1:0] BETA_ONE_RST     = RATE_W'(15099494);
    localparam logic [RATE_W-1:0] BETA_TWO_RST     = RATE_W'(16760438);
    localparam logic [RATE_W-1:0] EPSILON_TERM_RST = RATE_W'(1);

    // quotient widths of the three divisions
    localparam logic [6:0] MH_QW = 7'd39;
    localparam logic [6:0] VH_QW = 7'd40;
    localparam logic [6:0] ST_QW = 7'd34;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POW1,
        ST_POW2,
        ST_RD,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_G1,
        ST_G2,
        ST_V1,
        ST_V2,
        ST_V3,
        ST_DIV_MH,
        ST_DIV_VH,
        ST_SQRT,
        ST_NUM1,
        ST_NUM2,
        ST_NUM3,
        ST_DIV_ST,
        ST_FIN
    } state_t;

endpackage
`default_nettype wire

### sv/adam_if.sv
`default_nettype none
interface adam_in_if;
    import adam_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        param_index;
    logic                    new_step;
    logic signed [VAL_W-1:0] weight_in;
    logic signed [VAL_W-1:0] gradient;

    modport source (output valid, param_index, new_step, weight_in, gradient, input ready);
    modport sink (input valid, param_index, new_step, weight_in, gradient, output ready);
endinterface

interface adam_out_if;
    import adam_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        param_index_out;
    logic signed [VAL_W-1:0] weight_out;

    modport source (output valid, param_index_out, weight_out, input ready);
    modport sink (input valid, param_index_out, weight_out, output ready);
endinterface

interface adam_cfg_if;
    import adam_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [RATE_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### sv/adam_optimizer_update.sv
`default_nettype none
// channel   dir  payload
// in_ch     in   param_index, new_step, weight_in, gradient
// out_ch    out  param_index_out, weight_out
// cfg_ch    in   index, data (register write, always ready)
//
// one item passes from accept to result through the serial restoring divider
// (three quotients, one bit a cycle) and the bit-serial root
// after reset a clearing pass over all 4096 entries zeroes both moment stores,
// in_ch.ready stays low until it ends
// a finished result sits in the output register; the next item is taken
// meanwhile and waits in its final state if the output is still stalled
module adam_optimizer_update (
    input  wire logic  clk,
    input  wire logic  rst_n,
    adam_in_if.sink    in_ch,
    adam_out_if.source out_ch,
    adam_cfg_if.sink   cfg_ch
);
    import adam_pkg::*;

    state_t state_reg, state_next;

    // configuration
    logic [RATE_W-1:0] learn_rate_reg, beta_one_reg, beta_two_reg, epsilon_term_reg;

    // running powers of the betas
    logic [POW_W-1:0] p1_reg, p2_reg;

    // latched item
    logic [IDX_W-1:0]        idx_reg;
    logic                    new_step_reg;
    logic signed [VAL_W-1:0] w_reg, g_reg;

    // moment stores
    logic [VAL_W-1:0] m_mem [NUM_PARAMS];
    logic [VAL_W-1:0] v_mem [NUM_PARAMS];
    logic [VAL_W-1:0] m_rd_reg, v_rd_reg;
    logic [MEM_AW-1:0] clr_cnt_reg;

    // datapath
    logic signed [65:0] acc_reg;
    logic signed [VAL_W-1:0] m_reg;
    logic [VAL_W-1:0]  v_reg, g2_reg;
    logic              neg_reg;
    logic [38:0]       mh_reg;
    logic [32:0]       denom_reg;
    logic [33:0]       step_reg;

    // shared divider
    logic [63:0] dvd_reg;
    logic [32:0] rem_reg, dvs_reg;
    logic [39:0] quo_reg;
    logic [6:0]  cnt_reg;
    logic        sat_reg;

    // root unit
    logic [63:0] sx_reg, sr_reg, sb_reg;

    // output register
    logic                    out_valid_reg;
    logic [IDX_W-1:0]        out_idx_reg;
    logic signed [VAL_W-1:0] out_w_reg;

    // ---------------------------------------------------------------
    // shared multiplier operands
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic [VAL_W-1:0]   gmag;

    assign gmag = g_reg[VAL_W-1] ? VAL_W'(-g_reg) : g_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_POW1:
            begin
                mul_a = $signed({8'd0, p1_reg});
                mul_b = $signed({9'd0, beta_one_reg});
            end
            ST_POW2:
            begin
                mul_a = $signed({8'd0, p2_reg});
                mul_b = $signed({9'd0, beta_two_reg});
            end
            ST_M1:
            begin
                mul_a = $signed({9'd0, beta_one_reg});
                mul_b = $signed({m_rd_reg[VAL_W-1], m_rd_reg});
            end
            ST_M2:
            begin
                mul_a = $signed({8'd0, ONE_Q24 - {1'b0, beta_one_reg}});
                mul_b = $signed({g_reg[VAL_W-1], g_reg});
            end
            ST_G1:
            begin
                mul_a = $signed({1'b0, gmag});
                mul_b = $signed({1'b0, gmag});
            end
            ST_V1:
            begin
                mul_a = $signed({9'd0, beta_two_reg});
                mul_b = $signed({1'b0, v_rd_reg});
            end
            ST_V2:
            begin
                mul_a = $signed({8'd0, ONE_Q24 - {1'b0, beta_two_reg}});
                mul_b = $signed({1'b0, g2_reg});
            end
            ST_NUM1:
            begin
                mul_a = $signed({9'd0, learn_rate_reg});
                mul_b = $signed({13'd0, mh_reg[19:0]});
            end
            ST_NUM2:
            begin
                mul_a = $signed({9'd0, learn_rate_reg});
                mul_b = $signed({14'd0, mh_reg[38:20]});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // power update rounding
    logic [65:0] prod_rnd;
    assign prod_rnd = $unsigned(prod) + 66'(1 << 23);

    // m rounding, half away from zero, then clamp
    logic               acc_neg;
    logic [65:0]        acc_mag, acc_mag_rnd;
    logic [41:0]        m_q;
    logic signed [VAL_W-1:0] m_new;

    assign acc_neg     = acc_reg[65];
    assign acc_mag     = acc_neg ? $unsigned(-acc_reg) : $unsigned(acc_reg);
    assign acc_mag_rnd = acc_mag + 66'(1 << 23);
    assign m_q         = acc_mag_rnd[65:24];

    always_comb
    begin
        if (!acc_neg)
        begin
            m_new = (m_q > 42'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(m_q[31:0]);
        end
        else
        begin
            m_new = (m_q >= 42'h80000000) ? 32'sh80000000 : $signed(32'(-m_q[31:0]));
        end
    end

    // unsigned rounding of the accumulator (g2, v, num)
    logic [65:0] acc_rnd;
    logic [41:0] acc_q;
    logic [VAL_W-1:0] acc_q_clamp;

    assign acc_rnd     = $unsigned(acc_reg) + 66'(1 << 23);
    assign acc_q       = acc_rnd[65:24];
    assign acc_q_clamp = (acc_q > 42'hFFFFFFFF) ? 32'hFFFFFFFF : acc_q[31:0];

    // bias corrections, zero taken as one lsb
    logic [POW_W-1:0] bc1, bc2;
    assign bc1 = (p1_reg >= ONE_Q24) ? POW_W'(1) : ONE_Q24 - p1_reg;
    assign bc2 = (p2_reg >= ONE_Q24) ? POW_W'(1) : ONE_Q24 - p2_reg;

    logic [VAL_W-1:0] mmag;
    assign mmag = m_reg[VAL_W-1] ? VAL_W'(-m_reg) : m_reg;

    // ---------------------------------------------------------------
    // divider start values, picked by the state that launches it
    logic [63:0] src_dvd, src_hi, src_lo;
    logic [32:0] src_dvs;
    logic [6:0]  src_q;
    logic        src_sat;

    always_comb
    begin
        case (state_reg)
            ST_V3:
            begin
                src_dvd = {8'd0, mmag, 24'd0};
                src_dvs = {8'd0, bc1};
                src_q   = MH_QW;
            end
            ST_DIV_MH:
            begin
                src_dvd = {8'd0, v_reg, 24'd0};
                src_dvs = {8'd0, bc2};
                src_q   = VH_QW;
            end
            ST_NUM3:
            begin
                src_dvd = {acc_q[39:0], 24'd0};
                src_dvs = denom_reg;
                src_q   = ST_QW;
            end
            default:
            begin
                src_dvd = '0;
                src_dvs = 33'd1;
                src_q   = ST_QW;
            end
        endcase
    end

    assign src_hi  = src_dvd >> src_q;
    assign src_lo  = src_dvd << (7'd64 - src_q);
    assign src_sat = src_hi >= {31'd0, src_dvs};

    // one restoring step
    logic [33:0] rem_sh;
    logic        rem_ge;
    logic        div_done;

    assign rem_sh   = {rem_reg, dvd_reg[63]};
    assign rem_ge   = rem_sh >= {1'b0, dvs_reg};
    assign div_done = sat_reg || (cnt_reg == 7'd0);

    logic [39:0] mh_full, vh_full;
    assign mh_full = sat_reg ? 40'h7FFFFFFFFF : {1'b0, quo_reg[38:0]};
    assign vh_full = sat_reg ? 40'hFFFFFFFFFF : quo_reg;

    // one root step
    logic [63:0] sq_t;
    logic        sq_ge;
    assign sq_t  = sr_reg + sb_reg;
    assign sq_ge = sx_reg >= sq_t;

    logic [32:0] denom_raw;
    assign denom_raw = {1'b0, sr_reg[31:0]} + {9'd0, epsilon_term_reg};

    // final update with saturation
    logic signed [34:0] wn;
    logic signed [VAL_W-1:0] wn_sat;
    assign wn = neg_reg ? 35'(w_reg) + $signed({1'b0, step_reg})
                        : 35'(w_reg) - $signed({1'b0, step_reg});
    assign wn_sat = (wn > 35'sh07FFFFFFF) ? 32'sh7FFFFFFF :
                    (wn < -35'sh080000000) ? 32'sh80000000 : wn[31:0];

    logic in_range;
    assign in_range = {1'b0, idx_reg} < (IDX_W+1)'(NUM_PARAMS);

    logic out_load;

    // ---------------------------------------------------------------
    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (clr_cnt_reg == MEM_AW'(NUM_PARAMS - 1)) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = in_ch.new_step ? ST_POW1 : ST_RD;
                end
            end
            ST_POW1:   state_next = ST_POW2;
            ST_POW2:   state_next = ST_RD;
            ST_RD:     state_next = in_range ? ST_M1 : ST_FIN;
            ST_M1:     state_next = ST_M2;
            ST_M2:     state_next = ST_M3;
            ST_M3:     state_next = ST_G1;
            ST_G1:     state_next = ST_G2;
            ST_G2:     state_next = ST_V1;
            ST_V1:     state_next = ST_V2;
            ST_V2:     state_next = ST_V3;
            ST_V3:     state_next = ST_DIV_MH;
            ST_DIV_MH: if (div_done) state_next = ST_DIV_VH;
            ST_DIV_VH: if (div_done) state_next = ST_SQRT;
            ST_SQRT:   if (cnt_reg == 7'd0) state_next = ST_NUM1;
            ST_NUM1:   state_next = ST_NUM2;
            ST_NUM2:   state_next = ST_NUM3;
            ST_NUM3:   state_next = ST_DIV_ST;
            ST_DIV_ST: if (div_done) state_next = ST_FIN;
            ST_FIN:    if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    logic m_we, v_we;
    logic [MEM_AW-1:0] mem_waddr;
    logic [VAL_W-1:0]  m_wdata, v_wdata;

    always_comb
    begin
        in_ch.ready = (state_reg == ST_IDLE);
        out_load    = (state_reg == ST_FIN) && (!out_valid_reg || out_ch.ready);
        m_we        = (state_reg == ST_CLEAR) || (state_reg == ST_M3);
        v_we        = (state_reg == ST_CLEAR) || (state_reg == ST_V3);
        mem_waddr   = (state_reg == ST_CLEAR) ? clr_cnt_reg : idx_reg[MEM_AW-1:0];
        m_wdata     = (state_reg == ST_CLEAR) ? '0 : m_new;
        v_wdata     = (state_reg == ST_CLEAR) ? '0 : acc_q_clamp;
    end

    assign cfg_ch.ready           = 1'b1;
    assign out_ch.valid           = out_valid_reg;
    assign out_ch.param_index_out = out_idx_reg;
    assign out_ch.weight_out      = out_w_reg;

    // ---------------------------------------------------------------
    // moment stores, registered read at the latched index
    always_ff @(posedge clk)
    begin
        if (m_we)
        begin
            m_mem[mem_waddr] <= m_wdata;
        end
        m_rd_reg <= m_mem[idx_reg[MEM_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            v_mem[mem_waddr] <= v_wdata;
        end
        v_rd_reg <= v_mem[idx_reg[MEM_AW-1:0]];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
            p1_reg           <= ONE_Q24;
            p2_reg           <= ONE_Q24;
            learn_rate_reg   <= LEARN_RATE_RST;
            beta_one_reg     <= BETA_ONE_RST;
            beta_two_reg     <= BETA_TWO_RST;
            epsilon_term_reg <= EPSILON_TERM_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + MEM_AW'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_POW1)
            begin
                p1_reg <= prod_rnd[48:24];
            end
            if (state_reg == ST_POW2)
            begin
                p2_reg <= prod_rnd[48:24];
            end
            if (cfg_ch.valid)
            begin
                case (cfg_ch.index)
                    REG_LEARN_RATE:   learn_rate_reg   <= cfg_ch.data;
                    REG_BETA_ONE:     beta_one_reg     <= cfg_ch.data;
                    REG_BETA_TWO:     beta_two_reg     <= cfg_ch.data;
                    REG_EPSILON_TERM: epsilon_term_reg <= cfg_ch.data;
                    default:          ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                idx_reg      <= in_ch.param_index;
                new_step_reg <= in_ch.new_step;
                w_reg        <= in_ch.weight_in;
                g_reg        <= in_ch.gradient;
            end
            ST_RD:
            begin
                // out-of-range index passes the weight through
                step_reg <= '0;
                neg_reg  <= 1'b0;
            end
            ST_M1, ST_G1, ST_V1, ST_NUM1: acc_reg <= prod;
            ST_M2, ST_V2:                 acc_reg <= acc_reg + prod;
            ST_NUM2:                      acc_reg <= acc_reg + (prod <<< 20);
            ST_M3:
            begin
                m_reg   <= m_new;
                neg_reg <= m_new[VAL_W-1];
            end
            ST_G2: g2_reg <= acc_q_clamp;
            ST_V3, ST_NUM3:
            begin
                if (state_reg == ST_V3)
                begin
                    v_reg <= acc_q_clamp;
                end
                dvd_reg <= src_lo;
                rem_reg <= src_hi[32:0];
                dvs_reg <= src_dvs;
                sat_reg <= src_sat;
                cnt_reg <= src_q;
                quo_reg <= '0;
            end
            ST_DIV_MH, ST_DIV_VH, ST_DIV_ST:
            begin
                if (div_done)
                begin
                    if (state_reg == ST_DIV_MH)
                    begin
                        mh_reg  <= mh_full[38:0];
                        dvd_reg <= src_lo;
                        rem_reg <= src_hi[32:0];
                        dvs_reg <= src_dvs;
                        sat_reg <= src_sat;
                        cnt_reg <= src_q;
                        quo_reg <= '0;
                    end
                    else if (state_reg == ST_DIV_VH)
                    begin
                        sx_reg  <= {vh_full[39:0], 24'd0};
                        sr_reg  <= '0;
                        sb_reg  <= 64'd1 << 62;
                        cnt_reg <= 7'd32;
                    end
                    else
                    begin
                        step_reg <= (sat_reg || quo_reg[33:0] > 34'h200000000)
                                    ? 34'h200000000 : quo_reg[33:0];
                    end
                end
                else
                begin
                    rem_reg <= rem_ge ? 33'(rem_sh - {1'b0, dvs_reg}) : rem_sh[32:0];
                    quo_reg <= {quo_reg[38:0], rem_ge};
                    dvd_reg <= {dvd_reg[62:0], 1'b0};
                    cnt_reg <= cnt_reg - 7'd1;
                end
            end
            ST_SQRT:
            begin
                if (cnt_reg == 7'd0)
                begin
                    denom_reg <= (denom_raw == 33'd0) ? 33'd1 : denom_raw;
                end
                else
                begin
                    if (sq_ge)
                    begin
                        sx_reg <= sx_reg - sq_t;
                        sr_reg <= (sr_reg >> 1) + sb_reg;
                    end
                    else
                    begin
                        sr_reg <= sr_reg >> 1;
                    end
                    sb_reg  <= sb_reg >> 2;
                    cnt_reg <= cnt_reg - 7'd1;
                end
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    out_idx_reg <= idx_reg;
                    out_w_reg   <= wn_sat;
                end
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // remainder of the restoring divider never reaches the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIV_MH || state_reg == ST_DIV_VH || state_reg == ST_DIV_ST)
         && !sat_reg) |-> (rem_reg < dvs_reg))
        else $error("divider remainder not below divisor");

    // root bit stays one-hot while the root steps; it walks one position pair per step
    a_sqrt_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQRT && cnt_reg != 7'd0) |-> $onehot(sb_reg))
        else $error("root bit not one-hot");

    // no item taken while the stores are being cleared
    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ch.ready)
        else $error("item accepted during clearing pass");

    // powers of the betas never exceed one
    a_pow_range: assert property (@(posedge clk) disable iff (!rst_n)
        (p1_reg <= ONE_Q24) && (p2_reg <= ONE_Q24))
        else $error("beta power above one");

    // a taken result with nothing new behind it drops valid
    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ch.ready && !out_load) |=> !out_valid_reg)
        else $error("result repeated");

    // new_step path always runs both power updates
    a_pow_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POW1) |=> (state_reg == ST_POW2 && new_step_reg))
        else $error("power update sequence broken");

endmodule
`default_nettype wire
